// ===== rtl/psol_pkg.sv =====
`timescale 1ns / 1ps
// Package: request and status codes and beat field widths for the slot pool.
package psol_pkg;

    localparam int unsigned SLOT_W = 4;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BUFFERED = 2'd2,
        ST_NOT_USED = 2'd3
    } t_status;

    typedef struct packed {
        logic                        hvalid;
        logic [SLOT_W-1:0]           tail;
        logic [SLOT_W-1:0]           head;
        logic [SLOT_W-1:0]           granted;
        t_status                     status;
    } t_result;

endpackage

// ===== rtl/psol_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module psol_ram #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/psol_free_enc.sv =====
`timescale 1ns / 1ps
// Lowest-free-slot priority encoder over the slot usage bitmap.
module psol_free_enc #(
    parameter int unsigned NUM = 16
) (
    input  logic [NUM-1:0]         i_used,
    output logic                   o_found,
    output logic [$clog2(NUM)-1:0] o_idx
);

    always_comb begin
        o_idx = '0;
        for (int i = NUM - 1; i >= 0; i--) begin
            if (!i_used[i]) begin
                o_idx = ($clog2(NUM))'(i);
            end
        end
    end

    assign o_found = ~&i_used;

endmodule

// ===== rtl/packet_slot_pool_ordered_list.sv =====
`timescale 1ns / 1ps
// Top level: packet slot pool with arrival-ordered doubly linked list.
// An accepted beat enters update state S_EXEC; its result beat is registered on fire.
// A request is taken only once the last has left S_EXEC; the registered link RAM read
// (prev/next of the slot to unlink) sits between acceptance and update.
// A held output beat stalls the update stage; one more request is taken meanwhile.
// Reset: usage bitmap cleared, list empty, no output beat; link RAMs are not cleared.
module packet_slot_pool_ordered_list #(
    parameter int unsigned POOL_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // slot_index[3:0], already_buffered[4], zero pad
    input  logic [1:0]  i_s_tuser,   // req_type[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // granted_slot[3:0], head_slot[7:4], head_valid[8],
                                     // tail_slot[12:9], zero pad
    output logic [1:0]  o_m_tuser    // status[1:0]
);

    import psol_pkg::*;

    localparam int unsigned IW = $clog2(POOL_SLOTS);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                  r_state;
    t_req                    r_req;
    logic [SLOT_W-1:0]       r_idx;
    logic                    r_buf;
    logic [POOL_SLOTS-1:0]   r_used;
    logic [POOL_SLOTS-1:0]   n_used;
    logic [IW-1:0]           r_head, n_head;
    logic [IW-1:0]           r_tail, n_tail;
    logic                    r_nonempty, n_nonempty;
    logic                    r_m_valid;
    t_result                 r_res, n_res;

    logic                    s_accept;
    logic                    fire;
    logic                    free_found;
    logic [IW-1:0]           free_idx;
    logic [IW-1:0]           rd_next, rd_prev;
    logic [IW-1:0]           slot;
    logic                    idx_ok, slot_used, p_nil, n_nil;
    logic                    next_we, prev_we;
    logic [IW-1:0]           next_waddr, next_wdata, prev_waddr, prev_wdata;
    logic [IW-1:0]           in_slot;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign fire       = (r_state == S_EXEC) && (!r_m_valid || i_m_tready);
    assign in_slot    = IW'(i_s_tdata[SLOT_W-1:0]);

    psol_free_enc #(.NUM(POOL_SLOTS)) u_free_enc (
        .i_used  (r_used),
        .o_found (free_found),
        .o_idx   (free_idx)
    );

    psol_ram #(.WIDTH(IW), .DEPTH(POOL_SLOTS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_re    (s_accept),
        .i_raddr (in_slot),
        .o_rdata (rd_next)
    );

    psol_ram #(.WIDTH(IW), .DEPTH(POOL_SLOTS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_re    (s_accept),
        .i_raddr (in_slot),
        .o_rdata (rd_prev)
    );

    assign slot      = IW'(r_idx);
    assign idx_ok    = 32'(r_idx) < POOL_SLOTS;
    assign slot_used = idx_ok && r_used[slot];
    // head has no predecessor, tail no successor; those links are never stored
    assign p_nil     = (slot == r_head);
    assign n_nil     = (slot == r_tail);

    always_comb begin
        n_used       = r_used;
        n_head       = r_head;
        n_tail       = r_tail;
        n_nonempty   = r_nonempty;
        next_we      = 1'b0;
        next_waddr   = r_tail;
        next_wdata   = free_idx;
        prev_we      = 1'b0;
        prev_waddr   = free_idx;
        prev_wdata   = r_tail;
        n_res        = '0;
        n_res.status = ST_OK;
        unique case (r_req)
            REQ_ADD: begin
                priority if (r_buf) begin
                    n_res.status = ST_BUFFERED;
                end else if (!free_found) begin
                    n_res.status = ST_FULL;
                end else begin
                    n_used[free_idx] = 1'b1;
                    next_we          = fire && r_nonempty;
                    prev_we          = fire && r_nonempty;
                    if (!r_nonempty) begin
                        n_head = free_idx;
                    end
                    n_tail        = free_idx;
                    n_nonempty    = 1'b1;
                    n_res.granted = SLOT_W'(free_idx);
                end
            end
            REQ_REMOVE: begin
                n_res.granted = r_idx;
                if (!slot_used) begin
                    n_res.status = ST_NOT_USED;
                end else begin
                    n_used[slot] = 1'b0;
                    next_we      = fire && !p_nil && !n_nil;
                    next_waddr   = rd_prev;
                    next_wdata   = rd_next;
                    prev_we      = fire && !p_nil && !n_nil;
                    prev_waddr   = rd_next;
                    prev_wdata   = rd_prev;
                    if (p_nil) begin
                        n_head = rd_next;
                    end
                    if (n_nil) begin
                        n_tail = rd_prev;
                    end
                    n_nonempty = !(p_nil && n_nil);
                end
            end
            REQ_CLEAR: begin
                n_used     = '0;
                n_nonempty = 1'b0;
            end
            default: begin
            end
        endcase
        n_res.hvalid = n_nonempty;
        n_res.head   = n_nonempty ? SLOT_W'(n_head) : '0;
        n_res.tail   = n_nonempty ? SLOT_W'(n_tail) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= '0;
            r_nonempty <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (fire) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (fire) begin
                        r_state    <= S_IDLE;
                        r_used     <= n_used;
                        r_nonempty <= n_nonempty;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_req <= t_req'(i_s_tuser);
            r_idx <= i_s_tdata[SLOT_W-1:0];
            r_buf <= i_s_tdata[SLOT_W];
        end
        if (fire) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_res  <= n_res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_res.status;
    assign o_m_tdata  = {3'b000, r_res.tail, r_res.hvalid, r_res.head, r_res.granted};

    a_nonempty_matches_bitmap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nonempty == (|r_used))
        else $error("list nonempty flag disagrees with usage bitmap");

    a_ends_are_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nonempty |-> (r_used[r_head] && r_used[r_tail]))
        else $error("head or tail points at a free slot");

    a_writes_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (next_we || prev_we) |-> fire)
        else $error("link RAM written outside update");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == S_EXEC))
        else $error("accepted beat did not enter update stage");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for the packet slot pool: directed and random requests checked against a shadow list.
module testbench;
    import psol_pkg::*;

    localparam int          SLOTS       = 16;
    localparam logic [4:0]  NIL         = 5'd16;
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;
    localparam int          MAX_REPORTS = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;   // slot_index[3:0], already_buffered[4], zero pad
    logic [1:0]  i_s_tuser = '0;   // req_type[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;        // granted_slot[3:0], head_slot[7:4], head_valid[8],
                                   // tail_slot[12:9], zero pad
    logic [1:0]  o_m_tuser;        // status[1:0]

    packet_slot_pool_ordered_list #(.POOL_SLOTS(SLOTS)) dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow of the pool
    logic       pool_used [SLOTS];
    logic [4:0] link_next [SLOTS];
    logic [4:0] link_prev [SLOTS];
    logic [4:0] head_p = NIL;
    logic [4:0] tail_p = NIL;

    t_result pending_results[$];
    int      fail_count = 0;
    bit      src_idle_en = 1'b1;
    bit      sink_idle_en = 1'b1;
    int      hold_left = 0;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            pool_used[i] = 1'b0;
        end
    end

    function automatic t_result pool_request(logic [1:0] req, logic [3:0] idx, logic buffered);
        t_result    r;
        int         free_slot;
        logic [4:0] p;
        logic [4:0] n;
        r.status  = ST_OK;
        r.granted = '0;
        free_slot = -1;
        case (req)
            REQ_ADD: begin
                if (buffered) begin
                    r.status = ST_BUFFERED;
                end else begin
                    for (int i = SLOTS - 1; i >= 0; i--) begin
                        if (!pool_used[i]) free_slot = i;
                    end
                    if (free_slot < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        pool_used[free_slot] = 1'b1;
                        link_next[free_slot] = NIL;
                        if (tail_p == NIL) begin
                            link_prev[free_slot] = NIL;
                            head_p = 5'(free_slot);
                        end else begin
                            link_next[tail_p[3:0]] = 5'(free_slot);
                            link_prev[free_slot] = tail_p;
                        end
                        tail_p = 5'(free_slot);
                        r.granted = 4'(free_slot);
                    end
                end
            end
            REQ_REMOVE: begin
                r.granted = idx;
                if (!pool_used[idx]) begin
                    r.status = ST_NOT_USED;
                end else begin
                    p = link_prev[idx];
                    n = link_next[idx];
                    if (p != NIL) link_next[p[3:0]] = n;
                    else head_p = n;
                    if (n != NIL) link_prev[n[3:0]] = p;
                    else tail_p = p;
                    pool_used[idx] = 1'b0;
                end
            end
            REQ_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) begin
                    pool_used[i] = 1'b0;
                end
                head_p = NIL;
                tail_p = NIL;
            end
            default: ;
        endcase
        r.hvalid = (head_p != NIL);
        r.head   = r.hvalid ? head_p[3:0] : 4'd0;
        r.tail   = (r.hvalid && tail_p != NIL) ? tail_p[3:0] : 4'd0;
        return r;
    endfunction

    task automatic send_request(input logic [1:0] req, input logic [3:0] idx,
                                input logic buffered);
        int gap;
        gap = 0;
        @(negedge i_clk);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {3'b000, buffered, idx};
        i_s_tuser  = req;
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(pool_request(req, idx, buffered));
    endtask

    task automatic send_random(input bit fill_bias);
        int         pick;
        int         add_w;
        int         used_slots[$];
        logic [3:0] s;
        pick  = $urandom_range(0, 99);
        add_w = fill_bias ? 62 : 32;
        s     = 4'($urandom_range(0, SLOTS - 1));
        if (pick < add_w) begin
            send_request(REQ_ADD, s, $urandom_range(0, 9) == 0);
        end else if (pick < add_w + 30) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (pool_used[i]) used_slots.push_back(i);
            end
            if (used_slots.size() > 0) begin
                s = 4'(used_slots[$urandom_range(0, used_slots.size() - 1)]);
            end
            send_request(REQ_REMOVE, s, 1'($urandom));
        end else if (pick < 96) begin
            send_request(REQ_REMOVE, s, 1'($urandom));
        end else if (pick < 98) begin
            send_request(REQ_CLEAR, s, 1'($urandom));
        end else begin
            send_request(REQ_UNUSED, s, 1'($urandom));
        end
    endtask

    // result side: random stall bursts plus a long hold when asked
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_tready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                i_m_tready = 1'b0;
                stall_left--;
            end else if (sink_idle_en && $urandom_range(0, 6) == 0) begin
                i_m_tready = 1'b0;
                stall_left = $urandom_range(1, 10) - 1;
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status  = t_status'(o_m_tuser);
            got.granted = o_m_tdata[3:0];
            got.head    = o_m_tdata[7:4];
            got.hvalid  = o_m_tdata[8];
            got.tail    = o_m_tdata[12:9];
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result beat st=%0d granted=%0d at %0t",
                             got.status, got.granted, $realtime);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $write("mismatch at %0t: exp st=%0d granted=%0d head=%0d hv=%0b tail=%0d,",
                               $realtime, want.status, want.granted, want.head, want.hvalid,
                               want.tail);
                        $display(" got st=%0d granted=%0d head=%0d hv=%0b tail=%0d",
                                 got.status, got.granted, got.head, got.hvalid, got.tail);
                    end
                end
            end
        end
    end

    task automatic test_empty_pool();
        send_request(REQ_ADD, 4'd0, 1'b1);
        send_request(REQ_REMOVE, 4'd0, 1'b0);
        send_request(REQ_UNUSED, 4'd9, 1'b1);
        send_request(REQ_CLEAR, 4'd15, 1'b0);
    endtask

    task automatic test_fill_to_full();
        for (int i = 0; i < SLOTS; i++) begin
            send_request(REQ_ADD, 4'(i), 1'b0);
        end
        send_request(REQ_ADD, 4'd15, 1'b0);
        // buffered wins over full
        send_request(REQ_ADD, 4'd0, 1'b1);
    endtask

    task automatic test_unlink_positions();
        send_request(REQ_REMOVE, 4'd5, 1'b0);
        send_request(REQ_REMOVE, 4'd0, 1'b1);
        send_request(REQ_REMOVE, 4'd15, 1'b0);
        send_request(REQ_ADD, 4'd3, 1'b0);
    endtask

    task automatic test_clear_pool();
        send_request(REQ_CLEAR, 4'd10, 1'b1);
    endtask

    task automatic test_random(input int count, input bit idle);
        for (int k = 0; k < count; k++) begin
            src_idle_en  = idle && ((k / 150) % 3 != 2);
            sink_idle_en = idle && ((k / 120) % 4 != 3);
            send_random((k / 48) % 2 == 0);
        end
    endtask

    task automatic test_backpressure();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        @(posedge i_clk);
        hold_left = 300;
        for (int k = 0; k < 40; k++) begin
            send_random(1'b1);
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_empty_pool();
        test_fill_to_full();
        test_unlink_positions();
        test_clear_pool();
        test_random(700, 1'b1);
        test_backpressure();
        test_random(700, 1'b1);
        test_random(200, 1'b0);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/psol_pkg.sv
rtl/psol_ram.sv
rtl/psol_free_enc.sv
rtl/packet_slot_pool_ordered_list.sv
bench/testbench.sv
